@@ rtl/preemptive_priority_tick_scheduler_unit_defines.svh @@
// Assertion macros used by the scheduler RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef PREEMPTIVE_PRIORITY_TICK_SCHEDULER_UNIT_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_TICK_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define PPTSU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPTSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pptsu_pkg.sv @@
// Shared types and constants of the priority tick scheduler.
// No dependencies.
`timescale 1ns / 1ps

package pptsu_pkg;

    localparam logic [4:0] JOB_COUNT_RST = 5'd16;

    typedef enum logic [1:0] {
        K_SKIP,
        K_LOAD,
        K_TICK
    } t_kind;

    // one classified word between front and back
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  slot;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  urgency;
    } t_entry;

    typedef struct packed {
        logic [15:0] tick_time;
        logic        idle;
        logic [3:0]  running_slot;
        logic        finished;
        logic [15:0] first_start;
        logic [15:0] completion;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic        all_done;
    } t_result;

endpackage

@@ rtl/pptsu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pptsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pptsu_front.sv @@
// Front end: accepts input words, classifies them and queues them (two entries).
// Depends on pptsu_pkg.
`timescale 1ns / 1ps

module pptsu_front #(
    parameter int SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_operation,
    input  logic [3:0]       i_slot,
    input  logic [15:0]      i_arrival,
    input  logic [15:0]      i_burst,
    input  logic [7:0]       i_urgency,
    output logic             o_q_valid,
    output pptsu_pkg::t_entry o_q_entry,
    input  logic             i_q_pop
);

    localparam int AW = $clog2(SLOTS);
    // one bit above the slot index so SLOTS itself fits the compare
    localparam int XW = ((AW + 1) > 4) ? (AW + 1) : 4;

    pptsu_pkg::t_entry r_q [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    pptsu_pkg::t_entry w_entry;
    logic [XW-1:0]     w_slot_x;
    logic              w_push, w_pop;

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_entry  = r_q[r_rp];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_q_pop && o_q_valid;
    assign w_slot_x   = XW'(i_slot);

    always_comb begin
        w_entry.slot    = i_slot;
        w_entry.arrival = i_arrival;
        // a zero burst counts as one unit
        w_entry.burst   = (i_burst == 16'd0) ? 16'd1 : i_burst;
        w_entry.urgency = i_urgency;
        if (i_operation) begin
            w_entry.kind = pptsu_pkg::K_TICK;
        end else if (w_slot_x < XW'(SLOTS)) begin
            w_entry.kind = pptsu_pkg::K_LOAD;
        end else begin
            w_entry.kind = pptsu_pkg::K_SKIP;
        end
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_entry;
                r_wp      <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ rtl/pptsu_back.sv @@
// Back end: executes loads and ticks against the slot table, scans slots one per cycle.
// Depends on pptsu_pkg and pptsu_ram.
`timescale 1ns / 1ps

module pptsu_back #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [4:0]         i_job_count,
    input  logic               i_q_valid,
    input  pptsu_pkg::t_entry  i_q_entry,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pptsu_pkg::t_result o_res
);

    localparam int AW = $clog2(SLOTS);
    localparam int CNTW = AW + 1;
    localparam int NW = $clog2(SLOTS + 1);
    localparam int CW = (NW > 5) ? NW : 5;
    localparam int TB = TIME_BITS;
    localparam int MW = (TB > 16) ? TB : 16;

    typedef struct packed {
        logic [TB-1:0] start;
        logic [15:0]   rem;
        logic [7:0]    urg;
        logic [15:0]   burst;
        logic [15:0]   arr;
    } t_row;

    localparam int RW = $bits(t_row);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD
    } t_state;

    function automatic logic [15:0] f_lo16(input logic [TB-1:0] v);
        logic [MW-1:0] x;
        x = MW'(v);
        return x[15:0];
    endfunction

    t_state             r_state, n_state;
    logic [SLOTS-1:0]   r_started, n_started;
    logic [SLOTS-1:0]   r_done, n_done;
    logic [TB-1:0]      r_now, n_now;
    logic [CNTW-1:0]    r_cnt, n_cnt;
    logic               r_rd_v, n_rd_v;
    logic [AW-1:0]      r_rd_idx, n_rd_idx;
    logic               r_found, n_found;
    logic               r_frozen, n_frozen;
    logic [AW-1:0]      r_best_idx, n_best_idx;
    t_row               r_best, n_best;
    logic               r_out_valid, n_out_valid;
    pptsu_pkg::t_result r_res, n_res;

    logic               w_we, w_re;
    logic [AW-1:0]      w_waddr, w_raddr;
    t_row               w_wrow, w_rrow;
    logic [RW-1:0]      w_rdata;
    logic [CW-1:0]      w_jc, w_n;
    logic [SLOTS-1:0]   w_act;
    logic               w_all_done;
    logic               w_elig, w_better, w_fin;
    logic [TB-1:0]      w_compl, w_first, w_turn, w_wait;
    logic [AW-1:0]      w_ld_addr;

    pptsu_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wrow),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rrow    = t_row'(w_rdata);
    assign w_jc      = CW'(i_job_count);
    assign w_n       = (w_jc > CW'(SLOTS)) ? CW'(SLOTS) : w_jc;
    assign w_ld_addr = AW'(i_q_entry.slot);

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_act[i] = (CW'(i) < w_n);
        end
    end

    assign w_all_done = &(r_done | ~w_act);
    assign w_compl    = (&r_now) ? r_now : r_now + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_started   = r_started;
        n_done      = r_done;
        n_now       = r_now;
        n_cnt       = r_cnt;
        n_rd_v      = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_found     = r_found;
        n_frozen    = r_frozen;
        n_best_idx  = r_best_idx;
        n_best      = r_best;
        n_out_valid = r_out_valid && !i_out_ready;
        n_res       = r_res;
        o_q_pop     = 1'b0;
        w_we        = 1'b0;
        w_waddr     = w_ld_addr;
        w_wrow      = '0;
        w_re        = 1'b0;
        w_raddr     = AW'(r_cnt);
        w_elig      = 1'b0;
        w_better    = 1'b0;
        w_fin       = 1'b0;
        w_first     = r_now;
        w_turn      = '0;
        w_wait      = '0;

        case (r_state)
            S_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    case (i_q_entry.kind)
                        pptsu_pkg::K_LOAD: begin
                            w_we         = 1'b1;
                            w_wrow.start = '0;
                            w_wrow.rem   = i_q_entry.burst;
                            w_wrow.urg   = i_q_entry.urgency;
                            w_wrow.burst = i_q_entry.burst;
                            w_wrow.arr   = i_q_entry.arrival;
                            n_started[w_ld_addr] = 1'b0;
                            n_done[w_ld_addr]    = 1'b0;
                        end
                        pptsu_pkg::K_TICK: begin
                            n_found  = 1'b0;
                            n_frozen = w_all_done;
                            n_cnt    = '0;
                            n_state  = w_all_done ? S_UPD : S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue one slot address per cycle, judge it when the row returns
                if (r_cnt < CNTW'(SLOTS)) begin
                    w_re     = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                    n_rd_v   = 1'b1;
                    n_rd_idx = AW'(r_cnt);
                end
                if (r_rd_v) begin
                    w_elig   = !r_done[r_rd_idx] && w_act[r_rd_idx] &&
                               (MW'(w_rrow.arr) <= MW'(r_now));
                    w_better = !r_found || (w_rrow.urg > r_best.urg) ||
                               ((w_rrow.urg == r_best.urg) && (w_rrow.arr < r_best.arr));
                    if (w_elig && w_better) begin
                        n_found    = 1'b1;
                        n_best_idx = r_rd_idx;
                        n_best     = w_rrow;
                    end
                    if (r_rd_idx == AW'(SLOTS - 1)) begin
                        n_rd_v  = 1'b0;
                        n_state = S_UPD;
                    end
                end
            end

            S_UPD: begin
                w_first = r_started[r_best_idx] ? r_best.start : r_now;
                w_fin   = r_found && (r_best.rem <= 16'd1);
                w_turn  = TB'(MW'(w_compl) - MW'(r_best.arr));
                w_wait  = (MW'(w_turn) >= MW'(r_best.burst)) ?
                          TB'(MW'(w_turn) - MW'(r_best.burst)) : '0;
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_res.tick_time = f_lo16(r_now);
                    if (r_frozen) begin
                        n_res.idle         = 1'b1;
                        n_res.running_slot = 4'd0;
                        n_res.finished     = 1'b0;
                        n_res.first_start  = 16'd0;
                        n_res.completion   = f_lo16(r_now);
                        n_res.turnaround   = 16'd0;
                        n_res.waiting      = 16'd0;
                        n_res.all_done     = 1'b1;
                    end else begin
                        n_now = w_compl;
                        if (r_found) begin
                            w_we         = 1'b1;
                            w_waddr      = r_best_idx;
                            w_wrow       = r_best;
                            w_wrow.start = w_first;
                            w_wrow.rem   = w_fin ? 16'd0 : r_best.rem - 16'd1;
                            n_started[r_best_idx] = 1'b1;
                            if (w_fin) begin
                                n_done[r_best_idx] = 1'b1;
                            end
                        end
                        n_res.idle         = !r_found;
                        n_res.running_slot = r_found ? 4'(r_best_idx) : 4'd0;
                        n_res.finished     = w_fin;
                        n_res.first_start  = r_found ? f_lo16(w_first) : 16'd0;
                        n_res.completion   = f_lo16(w_compl);
                        n_res.turnaround   = w_fin ? f_lo16(w_turn) : 16'd0;
                        n_res.waiting      = w_fin ? f_lo16(w_wait) : 16'd0;
                        n_res.all_done     = &(n_done | ~w_act);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= '0;
            r_done      <= '0;
            r_now       <= '0;
            r_cnt       <= '0;
            r_rd_v      <= 1'b0;
            r_found     <= 1'b0;
            r_frozen    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_done      <= n_done;
            r_now       <= n_now;
            r_cnt       <= n_cnt;
            r_rd_v      <= n_rd_v;
            r_found     <= n_found;
            r_frozen    <= n_frozen;
            r_out_valid <= n_out_valid;
        end
        r_rd_idx   <= n_rd_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_res      <= n_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

@@ rtl/preemptive_priority_tick_scheduler_unit.sv @@
// Channel  | Signals                                        | Direction
// ---------+------------------------------------------------+----------
// input    | i_in_valid/o_in_ready, i_operation..i_urgency  | in
// result   | o_out_valid/i_out_ready, o_tick_time..o_all_done | out
// config   | i_cfg_valid/o_cfg_ready, i_cfg_data (job_count) | in
//
// A load is handled as it is dequeued. A tick is dequeued, then walks the slot
// table through its single read port, then updates in a state that waits while
// the held result is not yet taken. A frozen tick skips the walk. Synchronous
// active-low reset; no clearing pass. A two-word queue sits before the back end
// and a result register after it, so either side may stall without losing words.
`timescale 1ns / 1ps
`include "preemptive_priority_tick_scheduler_unit_defines.svh"

module preemptive_priority_tick_scheduler_unit #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [3:0]  i_slot,
    input  logic [15:0] i_arrival,
    input  logic [15:0] i_burst,
    input  logic [7:0]  i_urgency,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_tick_time,
    output logic        o_idle,
    output logic [3:0]  o_running_slot,
    output logic        o_finished,
    output logic [15:0] o_first_start,
    output logic [15:0] o_completion,
    output logic [15:0] o_turnaround,
    output logic [15:0] o_waiting,
    output logic        o_all_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    logic [4:0]         r_jc;
    logic               w_q_valid, w_q_pop;
    pptsu_pkg::t_entry  w_q_entry;
    pptsu_pkg::t_result w_res;
    logic               w_idle_clean;
    logic               w_frozen_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jc <= pptsu_pkg::JOB_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_jc <= i_cfg_data;
        end
    end

    pptsu_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_slot      (i_slot),
        .i_arrival   (i_arrival),
        .i_burst     (i_burst),
        .i_urgency   (i_urgency),
        .o_q_valid   (w_q_valid),
        .o_q_entry   (w_q_entry),
        .i_q_pop     (w_q_pop)
    );

    pptsu_back #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_count (r_jc),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_q_entry),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (w_res)
    );

    assign o_tick_time    = w_res.tick_time;
    assign o_idle         = w_res.idle;
    assign o_running_slot = w_res.running_slot;
    assign o_finished     = w_res.finished;
    assign o_first_start  = w_res.first_start;
    assign o_completion   = w_res.completion;
    assign o_turnaround   = w_res.turnaround;
    assign o_waiting      = w_res.waiting;
    assign o_all_done     = w_res.all_done;

    assign w_idle_clean = (o_running_slot == 4'd0) && !o_finished &&
                          (o_turnaround == 16'd0) && (o_first_start == 16'd0);
    assign w_frozen_res = o_out_valid && o_idle && o_all_done;

    // an idle tick serves nobody and finishes nothing
    `PPTSU_ASSERT_NOW(a_idle_empty, o_out_valid && o_idle, w_idle_clean, "idle result serves a job")

    // once everything is done, time stands still
    `PPTSU_ASSERT_NOW(a_frozen_time, w_frozen_res, o_completion == o_tick_time, "frozen tick moved")

    `PPTSU_ASSERT_NEXT(a_cfg_write, i_cfg_valid && o_cfg_ready, r_jc == $past(i_cfg_data), "cfg lost")

endmodule

@@ sim/preemptive_priority_tick_scheduler_unit_test.sv @@
// Self-checking bench for the preemptive priority tick scheduler unit.
// Uses pptsu_pkg for the result struct and the job_count reset value.
// Predicts every tick word in-bench and checks each result word field by field.
`timescale 1ns / 1ps

module preemptive_priority_tick_scheduler_unit_test;

    localparam int          NUM_SLOTS    = 16;
    localparam logic        OP_LOAD      = 1'b0;
    localparam logic        OP_TICK      = 1'b1;
    localparam logic [15:0] TIME_TOP     = 16'hFFFF;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          LONG_HOLD    = 400;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_operation = 1'b0;
    logic [3:0]  i_slot      = '0;
    logic [15:0] i_arrival   = '0;
    logic [15:0] i_burst     = '0;
    logic [7:0]  i_urgency   = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [4:0]  i_cfg_data  = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [15:0] o_tick_time;
    logic        o_idle;
    logic [3:0]  o_running_slot;
    logic        o_finished;
    logic [15:0] o_first_start;
    logic [15:0] o_completion;
    logic [15:0] o_turnaround;
    logic [15:0] o_waiting;
    logic        o_all_done;
    logic        o_cfg_ready;

    preemptive_priority_tick_scheduler_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_slot         (i_slot),
        .i_arrival      (i_arrival),
        .i_burst        (i_burst),
        .i_urgency      (i_urgency),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_tick_time    (o_tick_time),
        .o_idle         (o_idle),
        .o_running_slot (o_running_slot),
        .o_finished     (o_finished),
        .o_first_start  (o_first_start),
        .o_completion   (o_completion),
        .o_turnaround   (o_turnaround),
        .o_waiting      (o_waiting),
        .o_all_done     (o_all_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // job table as the scheduler should hold it
    logic [15:0] job_arrival [NUM_SLOTS];
    logic [15:0] job_burst   [NUM_SLOTS];
    logic [15:0] job_left    [NUM_SLOTS];
    logic [15:0] job_start   [NUM_SLOTS];
    logic [7:0]  job_urgency [NUM_SLOTS];
    bit          job_started [NUM_SLOTS];
    bit          job_done    [NUM_SLOTS];
    bit          job_loaded  [NUM_SLOTS];
    logic [15:0] sched_now     = '0;
    logic [4:0]  job_count_reg = pptsu_pkg::JOB_COUNT_RST;

    pptsu_pkg::t_result pending_ticks [$];
    int      mismatches    = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      stall_request = 0;
    int      stall_seen    = 0;
    int      hold_left     = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int active_jobs();
        return (job_count_reg > NUM_SLOTS) ? NUM_SLOTS : int'(job_count_reg);
    endfunction

    function automatic bit all_jobs_done();
        for (int i = 0; i < active_jobs(); i++)
            if (!job_done[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void store_job(logic [3:0] s, logic [15:0] arr, logic [15:0] brst,
                                      logic [7:0] urg);
        logic [15:0] b;
        b = (brst == 16'd0) ? 16'd1 : brst;
        job_arrival[s] = arr;
        job_burst[s]   = b;
        job_left[s]    = b;
        job_urgency[s] = urg;
        job_start[s]   = '0;
        job_started[s] = 1'b0;
        job_done[s]    = 1'b0;
        job_loaded[s]  = 1'b1;
    endfunction

    function automatic pptsu_pkg::t_result serve_tick();
        pptsu_pkg::t_result r;
        int          best;
        bit          found;
        logic [15:0] fin_time;
        r = '0;
        best = 0;
        found = 1'b0;
        r.tick_time = sched_now;
        if (all_jobs_done()) begin
            // frozen: time stands still
            r.idle = 1'b1;
            r.completion = sched_now;
            r.all_done = 1'b1;
            return r;
        end
        for (int i = 0; i < active_jobs(); i++) begin
            if (job_done[i] || job_arrival[i] > sched_now)
                continue;
            if (!found || job_urgency[i] > job_urgency[best] ||
                (job_urgency[i] == job_urgency[best] && job_arrival[i] < job_arrival[best])) begin
                found = 1'b1;
                best = i;
            end
        end
        fin_time = (sched_now == TIME_TOP) ? TIME_TOP : sched_now + 16'd1;
        if (found) begin
            if (!job_started[best]) begin
                job_started[best] = 1'b1;
                job_start[best] = sched_now;
            end
            r.running_slot = 4'(best);
            r.first_start = job_start[best];
            if (job_left[best] <= 16'd1) begin
                job_left[best] = '0;
                job_done[best] = 1'b1;
                r.finished = 1'b1;
                r.turnaround = fin_time - job_arrival[best];
                r.waiting = (r.turnaround >= job_burst[best]) ?
                            r.turnaround - job_burst[best] : 16'd0;
            end else begin
                job_left[best] = job_left[best] - 16'd1;
            end
        end
        sched_now = fin_time;
        r.idle = !found;
        r.completion = fin_time;
        r.all_done = all_jobs_done();
        return r;
    endfunction

    // one input word; valid stays up across back-to-back words
    task automatic send_word(logic op, logic [3:0] s, logic [15:0] arr, logic [15:0] brst,
                             logic [7:0] urg);
        pptsu_pkg::t_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_slot      <= s;
        i_arrival   <= arr;
        i_burst     <= brst;
        i_urgency   <= urg;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_TICK) begin
            pred = serve_tick();
            pending_ticks = {pending_ticks, pred};
        end else begin
            store_job(s, arr, brst, urg);
        end
    endtask

    task automatic send_tick();
        send_word(OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // only written with the block drained
    task automatic write_job_count(logic [4:0] value);
        i_in_valid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        job_count_reg = value;
        i_cfg_valid <= 1'b0;
    endtask

    // mostly loads near the current time and ticks; every active slot gets
    // loaded before any tick can scan it
    task automatic send_random_word();
        int          hole;
        int          n;
        logic [3:0]  s;
        logic [15:0] arr;
        logic [15:0] brst;
        logic [7:0]  urg;
        n = active_jobs();
        hole = -1;
        for (int i = n - 1; i >= 0; i--)
            if (!job_loaded[i])
                hole = i;
        if (hole < 0 && $urandom_range(99) >= 35) begin
            send_tick();
            return;
        end
        if (hole >= 0)
            s = 4'(hole);
        else if (n > 0 && $urandom_range(9) != 0)
            s = 4'($urandom_range(n - 1));
        else
            s = 4'($urandom);
        case ($urandom_range(9))
            0, 1:    arr = 16'($urandom);
            2, 3:    arr = (sched_now > 16'd20) ? sched_now - 16'($urandom_range(20)) : 16'd0;
            default: arr = (sched_now < 16'hFFF0) ? sched_now + 16'($urandom_range(12))
                                                  : sched_now;
        endcase
        case ($urandom_range(19))
            0:       brst = 16'd0;
            1:       brst = 16'($urandom);
            2, 3, 4: brst = 16'($urandom_range(40, 1));
            default: brst = 16'($urandom_range(6, 1));
        endcase
        urg = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
        send_word(OP_LOAD, s, arr, brst, urg);
    endtask

    task automatic compare_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_request != stall_seen) begin
            stall_seen = stall_request;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        pptsu_pkg::t_result want;
        pptsu_pkg::t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_tick_time, o_idle, o_running_slot, o_finished, o_first_start,
                   o_completion, o_turnaround, o_waiting, o_all_done};
            if (pending_ticks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with no tick pending", $time);
            end else begin
                want = pending_ticks.pop_front();
                compare_field("tick_time", want.tick_time, got.tick_time);
                compare_field("idle", want.idle, got.idle);
                compare_field("running_slot", want.running_slot, got.running_slot);
                compare_field("finished", want.finished, got.finished);
                compare_field("first_start", want.first_start, got.first_start);
                compare_field("completion", want.completion, got.completion);
                compare_field("turnaround", want.turnaround, got.turnaround);
                compare_field("waiting", want.waiting, got.waiting);
                compare_field("all_done", want.all_done, got.all_done);
            end
        end
    end

    // idle start, preemption, burst 0, ties on arrival and on slot index, a frozen tick
    task automatic test_priority_order();
        write_job_count(5'd5);
        send_word(OP_LOAD, 4'd0, 16'd2, 16'd1, 8'd5);
        send_word(OP_LOAD, 4'd1, 16'd1, 16'd1, 8'd5);
        send_word(OP_LOAD, 4'd2, 16'd1, 16'd3, 8'd100);
        send_word(OP_LOAD, 4'd3, 16'd2, 16'd0, 8'd255);
        send_word(OP_LOAD, 4'd4, 16'd2, 16'd1, 8'd5);
        repeat (9) send_tick();
    endtask

    task automatic test_job_count_edges();
        write_job_count(5'd0);
        send_word(OP_LOAD, 4'hF, 16'd0, 16'd0, 8'd0);
        repeat (2) send_tick();
        write_job_count(5'd1);
        send_word(OP_LOAD, 4'd0, TIME_TOP, 16'hFFFF, 8'hFF);
        send_tick();
        // reload clears started/done
        send_word(OP_LOAD, 4'd0, 16'd0, 16'd2, 8'd0);
        repeat (3) send_tick();
    endtask

    task automatic test_random_traffic(logic [4:0] jobs, int count);
        write_job_count(jobs);
        repeat (count) send_random_word();
    endtask

    // receiver holds off while words keep coming, so the input side must stall
    task automatic test_backpressure();
        write_job_count(5'd16);
        stall_request <= stall_request + 1;
        repeat (40) send_random_word();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 13;
        recv_idle_pct <= 71;
        test_priority_order();
        test_job_count_edges();
        test_random_traffic(5'd16, 100);
        test_random_traffic(5'd1, 90);
        test_random_traffic(5'd31, 100);

        send_idle_pct = 71;
        recv_idle_pct <= 13;
        test_random_traffic(5'd5, 100);
        test_random_traffic(5'd0, 30);
        test_random_traffic(5'd17, 100);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        test_backpressure();
        test_random_traffic(5'd8, 100);
        test_random_traffic(5'd2, 90);
        test_random_traffic(5'd12, 100);

        i_in_valid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pptsu_pkg.sv
rtl/pptsu_ram.sv
rtl/pptsu_front.sv
rtl/pptsu_back.sv
rtl/preemptive_priority_tick_scheduler_unit.sv
sim/preemptive_priority_tick_scheduler_unit_test.sv
